>>> src/ole_pkg.sv
package ole_pkg;

	// request kinds
	typedef logic [2:0] req_t;
	localparam req_t REQ_INSERT = 3'd0;
	localparam req_t REQ_ERASE  = 3'd1;
	localparam req_t REQ_FIND   = 3'd2;
	localparam req_t REQ_MODIFY = 3'd3;
	localparam req_t REQ_READ   = 3'd4;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_MISS  = 2'd3;

	// fixed port widths
	localparam int POS_W   = 9;
	localparam int FIELD_W = 32;
	localparam int IDX_W   = 8;

endpackage

>>> src/ole_ram.sv
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/ordered_list_insert_erase.sv
// ordered list of signed words held in one single-port-read ram
// input channel: an item (req_type, position, value) is taken when start is
// high and busy is low; busy stays high while the item is being worked on
// result channel: done is high for exactly one cycle with status,
// found_index, read_value and count; the receiver cannot stall it
// steps from accept to done, with n the count before the item:
//   insert          a read and a write per entry from n-1 down to position
//   erase           a read and a write per entry above position
//   find            a read and a compare per entry up to the first match or n
//   read            one ram read, then the result
//   modify, refused and unused kinds   answered straight from idle
// every list move is one ram read then one ram write through the shared
// index counter; one item is in flight at a time
// reset clears the count, so the list starts empty; ram contents need no
// clearing since only entries below the count are ever read
module ordered_list_insert_erase #(
	parameter int CAPACITY   = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          req_type,
	input  logic [8:0]          position,
	input  logic signed [31:0]  value,
	output logic                done,
	output logic [1:0]          status,
	output logic [7:0]          found_index,
	output logic signed [31:0]  read_value,
	output logic [8:0]          count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_WR  = 3'd2;
	localparam logic [2:0] S_ERS_RD  = 3'd3;
	localparam logic [2:0] S_ERS_WR  = 3'd4;
	localparam logic [2:0] S_FND_RD  = 3'd5;
	localparam logic [2:0] S_FND_CMP = 3'd6;
	localparam logic [2:0] S_RD_WAIT = 3'd7;

	logic [2:0]               state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            pos_q;
	logic [DATA_WIDTH-1:0]    word_q;
	logic                     done_q;
	ole_pkg::status_t         status_q;
	logic [ole_pkg::IDX_W-1:0] found_q;
	logic [ole_pkg::FIELD_W-1:0] rd_q;

	logic                  accept;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         cnt_ext;
	logic [DATA_WIDTH-1:0] in_word;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [CW-1:0]         idx_inc;

	assign accept  = start && (state_q == S_IDLE);
	assign pos_ext = PW'(position);
	assign cnt_ext = PW'(count_q);
	assign in_word = DATA_WIDTH'(value);
	assign idx_inc = CW'(idx_q + 1'b1);

	// ram port steering per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_waddr = AW'(position);
				ram_wdata = in_word;
				ram_raddr = AW'(position);
				ram_we    = accept && (req_type == ole_pkg::REQ_MODIFY) &&
					(pos_ext < cnt_ext);
			end
			S_INS_RD: begin
				ram_raddr = AW'(idx_q - 1'b1);
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = word_q;
				ram_we    = (idx_q == pos_q);
			end
			S_INS_WR: begin
				ram_we = 1'b1;
			end
			S_ERS_RD: begin
				ram_raddr = idx_inc[AW-1:0];
			end
			S_ERS_WR: begin
				ram_we = 1'b1;
			end
			S_FND_RD, S_FND_CMP, S_RD_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	ole_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ole_pkg::ST_OK;
			found_q  <= '0;
			rd_q     <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			word_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q    <= CW'(pos_ext);
						word_q   <= in_word;
						found_q  <= '0;
						rd_q     <= '0;
						status_q <= ole_pkg::ST_OK;
						unique case (req_type)
							ole_pkg::REQ_INSERT: begin
								if (pos_ext > cnt_ext) begin
									status_q <= ole_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else if (count_q >= CW'(CAPACITY)) begin
									status_q <= ole_pkg::ST_FULL;
									done_q   <= 1'b1;
								end else begin
									idx_q   <= count_q;
									state_q <= S_INS_RD;
								end
							end
							ole_pkg::REQ_ERASE: begin
								if (pos_ext >= cnt_ext) begin
									status_q <= ole_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									idx_q   <= CW'(pos_ext);
									state_q <= S_ERS_RD;
								end
							end
							ole_pkg::REQ_FIND: begin
								idx_q   <= '0;
								state_q <= S_FND_RD;
							end
							ole_pkg::REQ_MODIFY: begin
								if (pos_ext >= cnt_ext) begin
									status_q <= ole_pkg::ST_RANGE;
								end
								done_q <= 1'b1;
							end
							ole_pkg::REQ_READ: begin
								if (pos_ext >= cnt_ext) begin
									status_q <= ole_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				// insert: move entries up from the top down to the slot
				S_INS_RD: begin
					if (idx_q == pos_q) begin
						count_q <= CW'(count_q + 1'b1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= CW'(idx_q - 1'b1);
					state_q <= S_INS_RD;
				end
				// erase: move entries above the slot down by one
				S_ERS_RD: begin
					if (idx_inc >= count_q) begin
						count_q <= CW'(count_q - 1'b1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ERS_WR;
					end
				end
				S_ERS_WR: begin
					idx_q   <= idx_inc;
					state_q <= S_ERS_RD;
				end
				// find: linear scan, a ram read state then a compare state per entry
				S_FND_RD: begin
					if (idx_q == count_q) begin
						status_q <= ole_pkg::ST_MISS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_FND_CMP;
					end
				end
				S_FND_CMP: begin
					if (ram_rdata == word_q) begin
						found_q <= ole_pkg::IDX_W'(idx_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_FND_RD;
					end
				end
				// read: data arrives in the cycle after the address
				S_RD_WAIT: begin
					rd_q    <= ole_pkg::FIELD_W'($signed(ram_rdata));
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign read_value  = rd_q;
	assign count       = ole_pkg::POS_W'(count_q);

endmodule

>>> tb/sv/ordered_list_insert_erase_tb.sv
module ordered_list_insert_erase_tb;

	localparam int LIST_CAP = 256;
	localparam int POS_MAX = (1 << ole_pkg::POS_W) - 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 520;
	localparam ole_pkg::req_t REQ_UNUSED_LO = 3'd5;
	localparam ole_pkg::req_t REQ_UNUSED_HI = 3'd7;

	typedef struct {
		ole_pkg::status_t status;
		logic [ole_pkg::IDX_W-1:0] found;
		logic signed [ole_pkg::FIELD_W-1:0] rd;
		logic [ole_pkg::POS_W-1:0] cnt;
	} reply_t;

	// keeps a private copy of the list and the replies still owed by the block
	class list_checker;
		logic signed [ole_pkg::FIELD_W-1:0] entries [LIST_CAP];
		int num_entries;
		int peak_entries;
		reply_t replies_due[$];
		int errors;
		int kind_seen [8];
		int status_seen [4];

		function new();
			num_entries = 0;
			peak_entries = 0;
			errors = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// apply an accepted item to the list copy and queue its reply
		function void take_request(ole_pkg::req_t k, logic [ole_pkg::POS_W-1:0] p,
				logic signed [ole_pkg::FIELD_W-1:0] v);
			reply_t r;
			int pos;
			pos = int'(p);
			r.status = ole_pkg::ST_OK;
			r.found = '0;
			r.rd = '0;
			case (k)
				ole_pkg::REQ_INSERT: begin
					if (pos > num_entries) begin
						r.status = ole_pkg::ST_RANGE;
					end else if (num_entries >= LIST_CAP) begin
						r.status = ole_pkg::ST_FULL;
					end else begin
						for (int i = num_entries; i > pos; i--) entries[i] = entries[i-1];
						entries[pos] = v;
						num_entries++;
					end
				end
				ole_pkg::REQ_ERASE: begin
					if (pos >= num_entries) begin
						r.status = ole_pkg::ST_RANGE;
					end else begin
						for (int i = pos; i + 1 < num_entries; i++) entries[i] = entries[i+1];
						num_entries--;
					end
				end
				ole_pkg::REQ_FIND: begin
					r.status = ole_pkg::ST_MISS;
					for (int i = 0; i < num_entries; i++) begin
						if (entries[i] == v) begin
							r.status = ole_pkg::ST_OK;
							r.found = i[ole_pkg::IDX_W-1:0];
							break;
						end
					end
				end
				ole_pkg::REQ_MODIFY: begin
					if (pos >= num_entries) r.status = ole_pkg::ST_RANGE;
					else entries[pos] = v;
				end
				ole_pkg::REQ_READ: begin
					if (pos >= num_entries) r.status = ole_pkg::ST_RANGE;
					else r.rd = entries[pos];
				end
				default: begin
				end
			endcase
			r.cnt = num_entries[ole_pkg::POS_W-1:0];
			if (num_entries > peak_entries) peak_entries = num_entries;
			kind_seen[int'(k)]++;
			status_seen[int'(r.status)]++;
			replies_due.push_back(r);
		endfunction

		// compare one reply from the block against the oldest one owed
		function void compare_result(ole_pkg::status_t st, logic [ole_pkg::IDX_W-1:0] fi,
				logic signed [ole_pkg::FIELD_W-1:0] rv, logic [ole_pkg::POS_W-1:0] cnt);
			reply_t want;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: reply with none owed: status %0d count %0d", $time, st, cnt);
				return;
			end
			want = replies_due.pop_front();
			if (want.status !== st || want.found !== fi || want.rd !== rv ||
					want.cnt !== cnt) begin
				errors++;
				$display("%0t: reply mismatch: status exp %0d got %0d, found_index exp %0d got %0d,",
					$time, want.status, st, want.found, fi);
				$display("    read_value exp %0d got %0d, count exp %0d got %0d",
					want.rd, rv, want.cnt, cnt);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ole_pkg::req_t req_type;
	logic [ole_pkg::POS_W-1:0] position;
	logic signed [ole_pkg::FIELD_W-1:0] value;
	logic done;
	ole_pkg::status_t status;
	logic [ole_pkg::IDX_W-1:0] found_index;
	logic signed [ole_pkg::FIELD_W-1:0] read_value;
	logic [ole_pkg::POS_W-1:0] count;

	list_checker board = new();
	bit idle_on;
	int quiet_cycles;

	ordered_list_insert_erase #(
		.CAPACITY(LIST_CAP),
		.DATA_WIDTH(ole_pkg::FIELD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.found_index(found_index),
		.read_value(read_value),
		.count(count)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// replies are taken on every done cycle
	always @(posedge clk) begin
		if (arst_n && done) board.compare_result(status, found_index, read_value, count);
	end

	// watchdog on cycles with no item and no reply
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// present one item, with an optional idle burst first, and wait for it to be taken
	task automatic send_item(input ole_pkg::req_t k, input int p,
			input logic signed [ole_pkg::FIELD_W-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= k;
		position <= ole_pkg::POS_W'(p);
		value <= v;
		do @(posedge clk); while (busy);
		board.take_request(k, ole_pkg::POS_W'(p), v);
	endtask

	// mostly legal positions below n_valid, with the first illegal one and wild ones mixed in
	function automatic logic [ole_pkg::POS_W-1:0] pick_pos(input int n_valid);
		case ($urandom_range(0, 9))
			0: return ole_pkg::POS_W'($urandom_range(0, POS_MAX));
			1: return n_valid[ole_pkg::POS_W-1:0];
			default: return (n_valid > 0) ?
				ole_pkg::POS_W'($urandom_range(0, n_valid - 1)) : '0;
		endcase
	endfunction

	// small values repeat so find sees duplicates; extremes show up often
	function automatic logic signed [ole_pkg::FIELD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return $signed($urandom_range(0, 8)) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// one random item drawn with the given weights per request kind
	task automatic mixed_item(input int w_ins, input int w_ers, input int w_find,
			input int w_mod, input int w_read, input int w_unused);
		int r;
		int n;
		ole_pkg::req_t k;
		logic [ole_pkg::POS_W-1:0] p;
		logic signed [ole_pkg::FIELD_W-1:0] v;
		n = board.num_entries;
		r = $urandom_range(0, w_ins + w_ers + w_find + w_mod + w_read + w_unused - 1);
		v = pick_value();
		p = pick_pos(n);
		if (r < w_ins) begin
			k = ole_pkg::REQ_INSERT;
			p = pick_pos(n + 1);
		end else if (r < w_ins + w_ers) begin
			k = ole_pkg::REQ_ERASE;
		end else if (r < w_ins + w_ers + w_find) begin
			k = ole_pkg::REQ_FIND;
			p = ole_pkg::POS_W'($urandom_range(0, POS_MAX));
			if (n > 0 && $urandom_range(0, 2) != 0) v = board.entries[$urandom_range(0, n - 1)];
		end else if (r < w_ins + w_ers + w_find + w_mod) begin
			k = ole_pkg::REQ_MODIFY;
		end else if (r < w_ins + w_ers + w_find + w_mod + w_read) begin
			k = ole_pkg::REQ_READ;
		end else begin
			k = ole_pkg::req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			p = ole_pkg::POS_W'($urandom_range(0, POS_MAX));
		end
		send_item(k, int'(p), v);
	endtask

	initial begin
		arst_n = 1'b0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		start <= 1'b0;
		req_type <= ole_pkg::REQ_INSERT;
		position <= '0;
		value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every access refused, find misses, insert past the end refused
		send_item(ole_pkg::REQ_READ, 0, 0);
		send_item(ole_pkg::REQ_ERASE, 0, 0);
		send_item(ole_pkg::REQ_FIND, 0, 0);
		send_item(ole_pkg::REQ_MODIFY, 0, 1);
		send_item(ole_pkg::REQ_INSERT, 1, 5);
		// build [min, -1, max, -1] with front, middle and end inserts
		send_item(ole_pkg::REQ_INSERT, 0, 32'sh7fff_ffff);
		send_item(ole_pkg::REQ_INSERT, 0, 32'sh8000_0000);
		send_item(ole_pkg::REQ_INSERT, 2, -32'sd1);
		send_item(ole_pkg::REQ_INSERT, 1, -32'sd1);
		// first match wins on duplicates, miss on a present list
		send_item(ole_pkg::REQ_FIND, 0, -32'sd1);
		send_item(ole_pkg::REQ_FIND, POS_MAX, 32'sh8000_0000);
		send_item(ole_pkg::REQ_FIND, 0, 32'sd0);
		send_item(ole_pkg::REQ_READ, 3, 0);
		send_item(ole_pkg::REQ_READ, 4, 0);
		send_item(ole_pkg::REQ_MODIFY, 2, 32'sh5555_5555);
		// erase the last entry, then the first
		send_item(ole_pkg::REQ_ERASE, 3, 0);
		send_item(ole_pkg::REQ_ERASE, 0, 0);
		send_item(ole_pkg::REQ_FIND, 0, 32'sh5555_5555);
		send_item(ole_pkg::REQ_READ, POS_MAX, 0);
		send_item(ole_pkg::REQ_INSERT, POS_MAX, -32'sd1);
		// unused kinds leave everything alone
		send_item(REQ_UNUSED_LO, POS_MAX, -32'sd1);
		send_item(ole_pkg::req_t'(REQ_UNUSED_LO + 1), 256, 32'sh2aaa_aaaa);
		send_item(REQ_UNUSED_HI, 0, 0);
		send_item(ole_pkg::REQ_READ, 1, 0);
		send_item(ole_pkg::REQ_ERASE, 1, 0);

		// short lists, every kind
		repeat (120) begin
			if (board.num_entries < 20) mixed_item(30, 20, 15, 13, 15, 7);
			else mixed_item(10, 40, 15, 13, 15, 7);
		end

		// grow to capacity, mostly inserts
		while (board.num_entries < LIST_CAP) mixed_item(85, 0, 5, 5, 5, 0);

		// full list, no idling: refused inserts, deep finds, erase and refill
		idle_on = 1'b0;
		repeat (30) mixed_item(40, 15, 20, 10, 15, 0);

		start <= 1'b0;
		while (board.replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("items: %0d insert, %0d erase, %0d find, %0d modify, %0d read, %0d unused",
			board.kind_seen[ole_pkg::REQ_INSERT], board.kind_seen[ole_pkg::REQ_ERASE],
			board.kind_seen[ole_pkg::REQ_FIND], board.kind_seen[ole_pkg::REQ_MODIFY],
			board.kind_seen[ole_pkg::REQ_READ],
			board.kind_seen[int'(REQ_UNUSED_LO)] + board.kind_seen[int'(REQ_UNUSED_LO) + 1] +
			board.kind_seen[int'(REQ_UNUSED_HI)]);
		$display("outcomes: %0d ok, %0d full, %0d out of range, %0d not found; peak %0d entries",
			board.status_seen[ole_pkg::ST_OK], board.status_seen[ole_pkg::ST_FULL],
			board.status_seen[ole_pkg::ST_RANGE], board.status_seen[ole_pkg::ST_MISS],
			board.peak_entries);
		if (board.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
